// File: src/p2rj_pkg.sv
// Package for the pose2 point range Jacobian block.
// Shared types, step counts and saturation helpers. No dependencies.
package p2rj_pkg;

  localparam int TRIG_FRAC_BITS = 14;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 16;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic               zero;
  } side_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [15:0] q;
  } lane_t;

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) r = 32'sh7fffffff;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) r = 16'sh7fff;
    else if (v < -34'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// File: src/p2rj_sqrt_stage.sv
// One digit step of the pipelined integer square root (two radicand bits per beat).
// Depends on p2rj_pkg.
module p2rj_sqrt_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  logic [63:0]        x_i,
  input  logic [35:0]        rem_i,
  input  logic [31:0]        root_i,
  input  p2rj_pkg::side_t    side_i,
  output logic               v_o,
  output logic [63:0]        x_o,
  output logic [35:0]        rem_o,
  output logic [31:0]        root_o,
  output p2rj_pkg::side_t    side_o
);

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;
  logic        v_r;
  logic [63:0] x_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  p2rj_pkg::side_t side_r;

  assign rem_sh = {rem_i[33:0], x_i[63:62]};
  assign trial  = {2'b00, root_i, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_i[61:0], 2'b00};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {root_i[30:0], take};
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign x_o    = x_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// File: src/p2rj_div_stage.sv
// One restoring step of the two-lane pipelined divider (one quotient bit per beat).
// Depends on p2rj_pkg.
module p2rj_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  logic [47:0]        d_i,
  input  p2rj_pkg::lane_t    lx_i,
  input  p2rj_pkg::lane_t    ly_i,
  input  logic [31:0]        dist_i,
  input  p2rj_pkg::side_t    side_i,
  output logic               v_o,
  output logic [47:0]        d_o,
  output p2rj_pkg::lane_t    lx_o,
  output p2rj_pkg::lane_t    ly_o,
  output logic [31:0]        dist_o,
  output p2rj_pkg::side_t    side_o
);

  logic [48:0] dfx, dfy;
  logic        v_r;
  logic [47:0] d_r;
  p2rj_pkg::lane_t lx_r, ly_r;
  logic [31:0] dist_r;
  p2rj_pkg::side_t side_r;

  assign dfx = {1'b0, lx_i.rem} - {1'b0, d_i};
  assign dfy = {1'b0, ly_i.rem} - {1'b0, d_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r       <= {1'b0, d_i[47:1]};
      lx_r.rem  <= dfx[48] ? lx_i.rem : dfx[47:0];
      lx_r.q    <= {lx_i.q[14:0], ~dfx[48]};
      ly_r.rem  <= dfy[48] ? ly_i.rem : dfy[47:0];
      ly_r.q    <= {ly_i.q[14:0], ~dfy[48]};
      dist_r    <= dist_i;
      side_r    <= side_i;
    end
  end

  assign v_o    = v_r;
  assign d_o    = d_r;
  assign lx_o   = lx_r;
  assign ly_o   = ly_r;
  assign dist_o = dist_r;
  assign side_o = side_r;

endmodule

// File: src/pose2_point_range_jacobian.sv
// Pose2 to point range with Jacobians, top level.
// Uses p2rj_pkg, p2rj_sqrt_stage and p2rj_div_stage.
//
// Usage:
//   Input channel (in_*): one beat holds a pose (x, y, cos, sin) and a world
//   point. Result channel (out_*): one beat per input beat, in order, holding
//   the point in the pose frame, its range, the four range Jacobians and the
//   zero_range flag.
//   Pipeline from input beat to result: rotation (3), squares and sum (2),
//   a 32-stage square root, rounding (1), a 16-stage divider, and two
//   Jacobian stages.
//   Throughput: one beat per cycle while no stall freezes the pipeline; the pipeline carries a valid bit per stage.
//   Stall: when out_stall holds a waiting result, the whole pipeline freezes
//   and in_stall rises in the same cycle; nothing is lost or repeated.
//   Bubbles are not squeezed out: in_stall rises only while a result waits
//   in the output register.
//   Reset: rst_n low clears all stage valid bits; no clearing pass.
module pose2_point_range_jacobian (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [30:0] in_pose_x,
  input  logic signed [30:0] in_pose_y,
  input  logic signed [15:0] in_pose_cos,
  input  logic signed [15:0] in_pose_sin,
  input  logic signed [30:0] in_point_x,
  input  logic signed [30:0] in_point_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_local_x,
  output logic signed [31:0] out_local_y,
  output logic [31:0]        out_distance,
  output logic signed [15:0] out_jac_pose_x,
  output logic signed [15:0] out_jac_pose_y,
  output logic signed [15:0] out_jac_point_x,
  output logic signed [15:0] out_jac_point_y,
  output logic               out_zero_range
);

  localparam int SQ = p2rj_pkg::SQRT_STEPS;
  localparam int DV = p2rj_pkg::DIV_STEPS;
  localparam int TF = p2rj_pkg::TRIG_FRAC_BITS;

  logic en;

  // stage 1: differences
  logic               s1_v_r;
  logic signed [31:0] s1_dx_r, s1_dy_r;
  logic signed [15:0] s1_c_r, s1_s_r;
  // stage 2: products
  logic               s2_v_r;
  logic signed [47:0] s2_cdx_r, s2_sdy_r, s2_cdy_r, s2_sdx_r;
  logic signed [15:0] s2_c_r, s2_s_r;
  // stage 3: round and saturate
  logic               s3_v_r;
  logic signed [31:0] s3_lx_r, s3_ly_r;
  logic signed [15:0] s3_c_r, s3_s_r;
  logic signed [48:0] s3_sx, s3_sy;
  // stage 4: squares
  logic               s4_v_r;
  logic [63:0]        s4_qx_r, s4_qy_r;
  logic signed [63:0] s4_px, s4_py;
  p2rj_pkg::side_t    s4_side_r, s3_side;
  // stage 5: sum of squares
  logic               s5_v_r;
  logic [63:0]        s5_d2_r;
  p2rj_pkg::side_t    s5_side_r;

  logic               sq_v   [0:SQ];
  logic [63:0]        sq_x   [0:SQ];
  logic [35:0]        sq_rem [0:SQ];
  logic [31:0]        sq_root[0:SQ];
  p2rj_pkg::side_t    sq_side[0:SQ];

  // rounding stage and divider setup
  logic               rn_v_r;
  logic [31:0]        rn_dist_r;
  logic [47:0]        rn_d_r;
  p2rj_pkg::lane_t    rn_lx_r, rn_ly_r;
  p2rj_pkg::side_t    rn_side_r;
  logic [31:0]        rn_dist;
  logic [31:0]        ax, ay;

  logic               dv_v   [0:DV];
  logic [47:0]        dv_d   [0:DV];
  p2rj_pkg::lane_t    dv_lx  [0:DV];
  p2rj_pkg::lane_t    dv_ly  [0:DV];
  logic [31:0]        dv_dist[0:DV];
  p2rj_pkg::side_t    dv_side[0:DV];

  // unit vector and Jacobian products
  logic               uj_v_r;
  logic signed [15:0] uj_jpx_r, uj_jpy_r;
  logic signed [32:0] uj_uxc_r, uj_uys_r, uj_uxs_r, uj_uyc_r;
  logic [31:0]        uj_dist_r;
  p2rj_pkg::side_t    uj_side_r;
  logic signed [16:0] ux, uy;

  // output register
  logic               o_v_r;
  logic signed [31:0] o_lx_r, o_ly_r;
  logic [31:0]        o_dist_r;
  logic signed [15:0] o_jpx_r, o_jpy_r, o_jqx_r, o_jqy_r;
  logic               o_zero_r;
  logic signed [33:0] jqx_s, jqy_s;

  assign en       = !(o_v_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      rn_v_r <= 1'b0;
      uj_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      rn_v_r <= sq_v[SQ];
      uj_v_r <= dv_v[DV];
      o_v_r  <= uj_v_r;
    end
  end

  assign s3_sx = 49'(s2_cdx_r) + 49'(s2_sdy_r) + 49'sd8192;
  assign s3_sy = 49'(s2_cdy_r) - 49'(s2_sdx_r) + 49'sd8192;
  assign s4_px = s3_lx_r * s3_lx_r;
  assign s4_py = s3_ly_r * s3_ly_r;
  assign s3_side = {s3_lx_r, s3_ly_r, s3_c_r, s3_s_r,
                    (s3_lx_r == '0) && (s3_ly_r == '0)};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r   <= 32'(in_point_x) - 32'(in_pose_x);
      s1_dy_r   <= 32'(in_point_y) - 32'(in_pose_y);
      s1_c_r    <= in_pose_cos;
      s1_s_r    <= in_pose_sin;
      s2_cdx_r  <= 48'(s1_c_r) * 48'(s1_dx_r);
      s2_sdy_r  <= 48'(s1_s_r) * 48'(s1_dy_r);
      s2_cdy_r  <= 48'(s1_c_r) * 48'(s1_dy_r);
      s2_sdx_r  <= 48'(s1_s_r) * 48'(s1_dx_r);
      s2_c_r    <= s1_c_r;
      s2_s_r    <= s1_s_r;
      s3_lx_r   <= p2rj_pkg::sat32(s3_sx >>> TF);
      s3_ly_r   <= p2rj_pkg::sat32(s3_sy >>> TF);
      s3_c_r    <= s2_c_r;
      s3_s_r    <= s2_s_r;
      s4_qx_r   <= s4_px;
      s4_qy_r   <= s4_py;
      s4_side_r <= s3_side;
      s5_d2_r   <= s4_qx_r + s4_qy_r;
      s5_side_r <= s4_side_r;
    end
  end

  assign sq_v[0]    = s5_v_r;
  assign sq_x[0]    = s5_d2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s5_side_r;

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    p2rj_sqrt_stage u_sq (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(sq_v[i]), .x_i(sq_x[i]), .rem_i(sq_rem[i]),
      .root_i(sq_root[i]), .side_i(sq_side[i]),
      .v_o(sq_v[i+1]), .x_o(sq_x[i+1]), .rem_o(sq_rem[i+1]),
      .root_o(sq_root[i+1]), .side_o(sq_side[i+1])
    );
  end

  assign rn_dist = sq_root[SQ] + 32'(sq_rem[SQ] > {4'b0, sq_root[SQ]});
  assign ax = sq_side[SQ].lx[31] ? 32'(-sq_side[SQ].lx) : 32'(sq_side[SQ].lx);
  assign ay = sq_side[SQ].ly[31] ? 32'(-sq_side[SQ].ly) : 32'(sq_side[SQ].ly);

  always_ff @(posedge clk) begin
    if (en) begin
      rn_dist_r   <= sq_side[SQ].zero ? 32'd0 : rn_dist;
      rn_d_r      <= {1'b0, rn_dist, 15'b0};
      rn_lx_r.rem <= {2'b00, ax, 14'b0} + {17'b0, rn_dist[31:1]};
      rn_lx_r.q   <= '0;
      rn_ly_r.rem <= {2'b00, ay, 14'b0} + {17'b0, rn_dist[31:1]};
      rn_ly_r.q   <= '0;
      rn_side_r   <= sq_side[SQ];
    end
  end

  assign dv_v[0]    = rn_v_r;
  assign dv_d[0]    = rn_d_r;
  assign dv_lx[0]   = rn_lx_r;
  assign dv_ly[0]   = rn_ly_r;
  assign dv_dist[0] = rn_dist_r;
  assign dv_side[0] = rn_side_r;

  for (genvar i = 0; i < DV; i++) begin : g_div
    p2rj_div_stage u_dv (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_i(dv_v[i]), .d_i(dv_d[i]), .lx_i(dv_lx[i]), .ly_i(dv_ly[i]),
      .dist_i(dv_dist[i]), .side_i(dv_side[i]),
      .v_o(dv_v[i+1]), .d_o(dv_d[i+1]), .lx_o(dv_lx[i+1]), .ly_o(dv_ly[i+1]),
      .dist_o(dv_dist[i+1]), .side_o(dv_side[i+1])
    );
  end

  assign ux = dv_side[DV].lx[31] ? -$signed({1'b0, dv_lx[DV].q}) : $signed({1'b0, dv_lx[DV].q});
  assign uy = dv_side[DV].ly[31] ? -$signed({1'b0, dv_ly[DV].q}) : $signed({1'b0, dv_ly[DV].q});

  always_ff @(posedge clk) begin
    if (en) begin
      uj_jpx_r  <= p2rj_pkg::sat16(-34'(ux));
      uj_jpy_r  <= p2rj_pkg::sat16(-34'(uy));
      uj_uxc_r  <= 33'(ux) * 33'(dv_side[DV].c);
      uj_uys_r  <= 33'(uy) * 33'(dv_side[DV].s);
      uj_uxs_r  <= 33'(ux) * 33'(dv_side[DV].s);
      uj_uyc_r  <= 33'(uy) * 33'(dv_side[DV].c);
      uj_dist_r <= dv_dist[DV];
      uj_side_r <= dv_side[DV];
    end
  end

  assign jqx_s = (34'(uj_uxc_r) - 34'(uj_uys_r) + 34'sd8192) >>> TF;
  assign jqy_s = (34'(uj_uxs_r) + 34'(uj_uyc_r) + 34'sd8192) >>> TF;

  always_ff @(posedge clk) begin
    if (en) begin
      o_lx_r   <= uj_side_r.lx;
      o_ly_r   <= uj_side_r.ly;
      o_dist_r <= uj_dist_r;
      o_zero_r <= uj_side_r.zero;
      o_jpx_r  <= uj_side_r.zero ? 16'sd0 : uj_jpx_r;
      o_jpy_r  <= uj_side_r.zero ? 16'sd0 : uj_jpy_r;
      o_jqx_r  <= uj_side_r.zero ? 16'sd0 : p2rj_pkg::sat16(jqx_s);
      o_jqy_r  <= uj_side_r.zero ? 16'sd0 : p2rj_pkg::sat16(jqy_s);
    end
  end

  assign out_valid       = o_v_r;
  assign out_local_x     = o_lx_r;
  assign out_local_y     = o_ly_r;
  assign out_distance    = o_dist_r;
  assign out_jac_pose_x  = o_jpx_r;
  assign out_jac_pose_y  = o_jpy_r;
  assign out_jac_point_x = o_jqx_r;
  assign out_jac_point_y = o_jqy_r;
  assign out_zero_range  = o_zero_r;

  a_zero_forces: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_range |->
      out_distance == '0 && out_jac_pose_x == '0 && out_jac_point_y == '0)
    else $error("zero range without cleared outputs");

  a_nonzero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_range |-> out_distance != '0)
    else $error("nonzero local point with zero distance");

  a_pose_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_local_x[31] |-> out_jac_pose_x[15] || out_jac_pose_x == '0)
    else $error("pose Jacobian sign mismatch");

endmodule

// File: bench/p2rj_checker.sv
// Checker for pose2_point_range_jacobian: watches both channels, predicts each
// result from the accepted input beat and compares it field by field.
// Depends on nothing but the port widths of the block.
module p2rj_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [30:0] in_pose_x,
  input  logic signed [30:0] in_pose_y,
  input  logic signed [15:0] in_pose_cos,
  input  logic signed [15:0] in_pose_sin,
  input  logic signed [30:0] in_point_x,
  input  logic signed [30:0] in_point_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_local_x,
  input  logic signed [31:0] out_local_y,
  input  logic [31:0]        out_distance,
  input  logic signed [15:0] out_jac_pose_x,
  input  logic signed [15:0] out_jac_pose_y,
  input  logic signed [15:0] out_jac_point_x,
  input  logic signed [15:0] out_jac_point_y,
  input  logic               out_zero_range,
  output int                 fail_count,
  output int                 pending,
  output int                 zero_seen,
  output int                 sat_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TFB = 14;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic [31:0]        rng;
    logic signed [15:0] jpx;
    logic signed [15:0] jpy;
    logic signed [15:0] jqx;
    logic signed [15:0] jqy;
    logic               zero;
  } range_res_t;

  range_res_t range_q[$];

  function automatic longint round_down(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (x > r) r++;
    return r;
  endfunction

  function automatic longint unit_part(longint l, longint unsigned n);
    longint unsigned mag, q;
    mag = longint'(l < 0 ? -l : l) << TFB;
    q = (mag + n / 2) / n;
    return clamp(l < 0 ? -longint'(q) : longint'(q), -32768, 32767);
  endfunction

  function automatic range_res_t predict_range(longint px, longint py, longint c,
                                               longint s, longint qx, longint qy);
    range_res_t r;
    longint dx, dy, lx, ly, ux, uy;
    longint unsigned d2;
    dx = qx - px;
    dy = qy - py;
    lx = clamp(round_down(c * dx + s * dy, TFB), -64'sd2147483648, 64'sd2147483647);
    ly = clamp(round_down(c * dy - s * dx, TFB), -64'sd2147483648, 64'sd2147483647);
    d2 = longint'(lx * lx) + longint'(ly * ly);
    r = '0;
    r.lx = 32'(lx);
    r.ly = 32'(ly);
    r.zero = (d2 == 0);
    if (!r.zero) begin
      r.rng = 32'(root_nearest(d2));
      ux = unit_part(lx, r.rng);
      uy = unit_part(ly, r.rng);
      r.jpx = 16'(clamp(-ux, -32768, 32767));
      r.jpy = 16'(clamp(-uy, -32768, 32767));
      r.jqx = 16'(clamp(round_down(ux * c - uy * s, TFB), -32768, 32767));
      r.jqy = 16'(clamp(round_down(ux * s + uy * c, TFB), -32768, 32767));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    range_res_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
      zero_seen <= 0;
      sat_seen <= 0;
      range_q.delete();
    end else begin
      if (in_valid && !in_stall)
        range_q.push_back(predict_range(in_pose_x, in_pose_y, in_pose_cos, in_pose_sin,
                                        in_point_x, in_point_y));
      if (out_valid && !out_stall) begin
        got = {out_local_x, out_local_y, out_distance, out_jac_pose_x, out_jac_pose_y,
               out_jac_point_x, out_jac_point_y, out_zero_range};
        if (range_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = range_q.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected lx=%0d ly=%0d d=%0d jp=%0d,%0d jq=%0d,%0d z=%0b",
                     $time, want.lx, want.ly, want.rng, want.jpx, want.jpy, want.jqx,
                     want.jqy, want.zero);
            $display("%0t:          actual   lx=%0d ly=%0d d=%0d jp=%0d,%0d jq=%0d,%0d z=%0b",
                     $time, got.lx, got.ly, got.rng, got.jpx, got.jpy, got.jqx,
                     got.jqy, got.zero);
            fail_count <= fail_count + 1;
          end
          if (got.zero) zero_seen <= zero_seen + 1;
          if (got.lx == 32'sh7fffffff || got.lx == 32'sh80000000) sat_seen <= sat_seen + 1;
        end
      end
    end
  end

  assign pending = range_q.size();
endmodule

// File: bench/tb_pose2_point_range_jacobian.sv
// Testbench top for pose2_point_range_jacobian: drives directed and random
// beats with random gaps and stalls, and a long output hold-off.
// Depends on the block and on p2rj_checker.
module tb_pose2_point_range_jacobian;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1400;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [30:0] in_pose_x = '0, in_pose_y = '0, in_point_x = '0, in_point_y = '0;
  logic signed [15:0] in_pose_cos = '0, in_pose_sin = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_local_x, out_local_y;
  logic [31:0] out_distance;
  logic signed [15:0] out_jac_pose_x, out_jac_pose_y, out_jac_point_x, out_jac_point_y;
  logic out_zero_range;
  int fail_count, pending, zero_seen, sat_seen;
  int cycles = 0;
  int beats = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  always #1 clk = ~clk;

  pose2_point_range_jacobian dut (.*);

  p2rj_checker u_chk (.*);

  function automatic logic [30:0] coord_pick(int mode);
    case (mode)
      0: return 31'h3fffffff;
      1: return 31'h40000000;
      2: return 31'($urandom_range(0, 2000)) - 31'd1000;
      3: return 31'($urandom_range(0, 200000)) - 31'd100000;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] trig_pick(int mode);
    case (mode)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'hc000;
      4: return 16'h0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic [30:0] px, logic [30:0] py, logic [15:0] c, logic [15:0] s,
                      logic [30:0] qx, logic [30:0] qy);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pose_x <= px;
    in_pose_y <= py;
    in_pose_cos <= c;
    in_pose_sin <= s;
    in_point_x <= qx;
    in_point_y <= qy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats++;
  endtask

  always @(posedge clk) begin
    int wait_n;
    if (rst_n) begin
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (out_stall) begin
        out_stall <= $urandom_range(0, 14) != 0 && $urandom_range(0, 1) == 0;
      end else begin
        wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
        out_stall <= wait_n > 9;
      end
    end
  end

  initial begin
    repeat (120) @(posedge clk);
    wait (rst_n);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(0, 0, 16'h4000, 0, 0, 0);
    send(31'h1234, 31'h777, 16'h7fff, 16'h7fff, 31'h1234, 31'h777);
    send(0, 0, 16'h4000, 0, 31'h10000, 0);
    send(0, 0, 16'h4000, 0, 0, 31'h10000);
    send(31'h40000000, 31'h40000000, 16'h7fff, 16'h7fff, 31'h3fffffff, 31'h3fffffff);
    send(31'h3fffffff, 31'h40000000, 16'h8000, 16'h8000, 31'h40000000, 31'h3fffffff);
    send(31'h40000000, 0, 16'h8000, 0, 31'h3fffffff, 0);
    send(0, 0, 16'h8000, 16'h8000, 1, 1);
    send(0, 0, 16'h7fff, 0, 1, 0);
    send(0, 0, 16'h0, 16'h0, 31'h10000, 31'h10000);
    send(0, 0, 16'h2d41, 16'h2d41, 31'h7fff, 31'h4000);
    send(0, 0, 16'hc000, 16'h4000, 31'h7ffffff0, 31'h12345);
    send(31'h7fffffff, 31'h7fffffff, 16'h7fff, 16'h8000, 31'h3fffffff, 31'h1);
    send(0, 0, 16'h4000, 0, 31'h7fffffff, 0);
    send(0, 0, 16'h4000, 0, 0, 31'h40000000);
    for (int i = 0; i < N_RANDOM; i++) begin
      m = $urandom_range(0, 9);
      if (m == 0)
        send(coord_pick(4), coord_pick(4), trig_pick(4), trig_pick(5), coord_pick(4),
             coord_pick(4));
      else
        send(coord_pick($urandom_range(0, 4)), coord_pick($urandom_range(0, 4)),
             trig_pick($urandom_range(0, 5)), trig_pick($urandom_range(0, 5)),
             coord_pick($urandom_range(0, 4)), coord_pick($urandom_range(0, 4)));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Ran %0d input beats with random gaps, stalls and a long output hold-off;",
             beats);
    $display("%0d zero-range results and %0d saturated local_x results seen.",
             zero_seen, sat_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: files.f
src/p2rj_pkg.sv
src/p2rj_sqrt_stage.sv
src/p2rj_div_stage.sv
src/pose2_point_range_jacobian.sv
bench/p2rj_checker.sv
bench/tb_pose2_point_range_jacobian.sv
